### sv/hpt_pkg.sv
`default_nettype none

package hpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int DIV_STEPS = 32;

  localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } hpt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               overflow;
    logic               divide_by_zero;
  } hpt_out_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lowq;
  } hpt_lane_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0]        big;
    logic [2:0][31:0]  v;
    logic              ovf;
    logic              dz;
    logic              unit;
  } hpt_side_t;

  typedef struct packed {
    logic [31:0]           d;
    hpt_lane_t [2:0]       ln;
    hpt_side_t             sd;
  } hpt_div_t;

endpackage

`default_nettype wire

### sv/hpt_div_cell.sv
`default_nettype none

module hpt_div_cell
  import hpt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     vld_i,
  input  wire hpt_div_t dat_i,
  output logic          vld_o,
  output hpt_div_t      dat_o
);

  logic      vld_r;
  hpt_div_t  dat_r;
  hpt_div_t  dat_nxt;
  logic [32:0] t    [3];
  logic [32:0] diff [3];
  logic [2:0]  ge;

  // one restoring step per lane
  always_comb begin
    dat_nxt = dat_i;
    for (int k = 0; k < 3; k++) begin
      t[k]    = {dat_i.ln[k].rem, dat_i.ln[k].lowq[31]};
      diff[k] = t[k] - {1'b0, dat_i.d};
      ge[k]   = t[k] >= {1'b0, dat_i.d};
      dat_nxt.ln[k].rem  = ge[k] ? diff[k][31:0] : t[k][31:0];
      dat_nxt.ln[k].lowq = {dat_i.ln[k].lowq[30:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

`default_nettype wire

### sv/homogeneous_point_transform_unit.sv
`default_nettype none

// Homogeneous 4x4 point transform with perspective divide, signed Q16.16.
// Takes one point per cycle while not stalled and returns one result per
// point, in order. The path runs through two arithmetic stages (products,
// column sums), a combinational divider set-up, a chain of 32 divider cells
// each producing one quotient bit for all three lanes, and the output
// register. A stall on a valid output freezes the whole pipe.
// Matrix registers reset to identity and must only be written while idle.
module homogeneous_point_transform_unit
  import hpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire hpt_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output hpt_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic signed [66:0] HI_MAX = 67'sd2147483647;
  localparam logic signed [66:0] HI_MIN = -67'sd2147483648;

  logic [CFG_W-1:0] cfg_r [NUM_REGS];
  logic signed [31:0] m [4][4];
  logic signed [31:0] pt [3];

  logic adv;

  logic               s1_vld_r;
  logic signed [63:0] p_r   [4][3];
  logic signed [63:0] p_nxt [4][3];

  logic               s2_vld_r;
  logic signed [31:0] v_r   [4];
  logic signed [31:0] v_nxt [4];
  logic               s2_ovf_r;
  logic               s2_ovf_nxt;
  logic signed [65:0] s  [4];
  logic signed [65:0] sh [4];
  logic signed [66:0] hi [4];
  logic [3:0]         sat;

  hpt_div_t           prep;
  logic [31:0]        av [3];
  logic [31+FRAC_BITS:0] dd [3];

  logic               cv [DIV_STEPS+1];
  hpt_div_t           cd [DIV_STEPS+1];

  logic               out_valid_r;
  hpt_out_t           out_r;
  hpt_out_t           out_nxt;
  logic signed [31:0] res [3];
  logic [2:0]         qovf;
  logic [31:0]        q;
  hpt_side_t          fs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == 0 || i == 5) begin
          cfg_r[i] <= CFG_W'(1) << FRAC_BITS;
        end else if (i == 2 || i == 7) begin
          cfg_r[i] <= CFG_W'(1) << (32 + FRAC_BITS);
        end else begin
          cfg_r[i] <= '0;
        end
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = cfg_r[2*r][31:0];
      m[r][1] = cfg_r[2*r][63:32];
      m[r][2] = cfg_r[2*r+1][31:0];
      m[r][3] = cfg_r[2*r+1][63:32];
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign pt[0] = in_data.in_x;
  assign pt[1] = in_data.in_y;
  assign pt[2] = in_data.in_z;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        p_nxt[c][r] = pt[r] * m[r][c];
      end
    end
  end

  // floor of the exact sum, then translation, then saturation
  always_comb begin
    s2_ovf_nxt = 1'b0;
    for (int c = 0; c < 4; c++) begin
      s[c]  = {{2{p_r[c][0][63]}}, p_r[c][0]} + {{2{p_r[c][1][63]}}, p_r[c][1]}
            + {{2{p_r[c][2][63]}}, p_r[c][2]};
      sh[c] = s[c] >>> FRAC_BITS;
      hi[c] = {sh[c][65], sh[c]} + {{35{m[3][c][31]}}, m[3][c]};
      sat[c] = 1'b1;
      if (hi[c] > HI_MAX) begin
        v_nxt[c] = 32'sh7fffffff;
      end else if (hi[c] < HI_MIN) begin
        v_nxt[c] = 32'sh80000000;
      end else begin
        v_nxt[c] = hi[c][31:0];
        sat[c]   = 1'b0;
      end
    end
    s2_ovf_nxt = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r      <= p_nxt;
      v_r      <= v_nxt;
      s2_ovf_r <= s2_ovf_nxt;
    end
  end

  // divider set-up: magnitudes, signs, quotient-too-large check
  always_comb begin
    prep         = '0;
    prep.d       = v_r[3][31] ? 32'(-v_r[3]) : v_r[3];
    prep.sd.ovf  = s2_ovf_r;
    prep.sd.dz   = v_r[3] == 32'sd0;
    prep.sd.unit = v_r[3] == ONE_FIX;
    for (int k = 0; k < 3; k++) begin
      av[k]             = v_r[k][31] ? 32'(-v_r[k]) : v_r[k];
      dd[k]             = {av[k], {FRAC_BITS{1'b0}}};
      prep.sd.v[k]      = v_r[k];
      prep.sd.neg[k]    = v_r[k][31] ^ v_r[3][31];
      prep.sd.big[k]    = 32'(dd[k][31+FRAC_BITS:32]) >= prep.d;
      prep.ln[k].rem    = 32'(dd[k][31+FRAC_BITS:32]);
      prep.ln[k].lowq   = dd[k][31:0];
    end
  end

  assign cv[0] = s2_vld_r;
  assign cd[0] = prep;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    hpt_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (cv[g]),
      .dat_i (cd[g]),
      .vld_o (cv[g+1]),
      .dat_o (cd[g+1])
    );
  end

  always_comb begin
    fs = cd[DIV_STEPS].sd;
    for (int k = 0; k < 3; k++) begin
      q       = cd[DIV_STEPS].ln[k].lowq;
      qovf[k] = 1'b0;
      if (fs.dz) begin
        res[k] = '0;
      end else if (fs.unit) begin
        res[k] = fs.v[k];
      end else if (fs.big[k]) begin
        qovf[k] = 1'b1;
        res[k]  = fs.neg[k] ? 32'sh80000000 : 32'sh7fffffff;
      end else if (fs.neg[k]) begin
        if (q > 32'h80000000) begin
          qovf[k] = 1'b1;
          res[k]  = 32'sh80000000;
        end else begin
          res[k] = 32'(-q);
        end
      end else if (q[31]) begin
        qovf[k] = 1'b1;
        res[k]  = 32'sh7fffffff;
      end else begin
        res[k] = q;
      end
    end
    out_nxt.out_x          = res[0];
    out_nxt.out_y          = res[1];
    out_nxt.out_z          = res[2];
    out_nxt.overflow       = fs.ovf || (|qovf);
    out_nxt.divide_by_zero = fs.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
